[sv/lcc_pkg.sv]
// Shared constants, sizes and types of the label contingency counter.
// No dependencies.
`timescale 1ns / 1ps
package lcc_pkg;

  localparam int unsigned SEG_ENTRIES   = 1024;
  localparam int unsigned TRUTH_ENTRIES = 1024;
  localparam int unsigned PAIR_ENTRIES  = 4096;
  localparam int unsigned COUNT_BITS    = 40;

  localparam int unsigned KEY_W = 64;

  localparam int unsigned SEG_AW   = $clog2(SEG_ENTRIES);
  localparam int unsigned TRUTH_AW = $clog2(TRUTH_ENTRIES);
  localparam int unsigned PAIR_AW  = $clog2(PAIR_ENTRIES);
  localparam int unsigned SEG_FW   = $clog2(SEG_ENTRIES + 1);
  localparam int unsigned TRUTH_FW = $clog2(TRUTH_ENTRIES + 1);
  localparam int unsigned PAIR_FW  = $clog2(PAIR_ENTRIES + 1);

  // scan index width: widest table address
  localparam int unsigned IW0 = (SEG_AW > TRUTH_AW) ? SEG_AW : TRUTH_AW;
  localparam int unsigned IW  = (IW0 > PAIR_AW) ? IW0 : PAIR_AW;
  // compare width: widest fill, at least one bit above the 12-bit read index
  localparam int unsigned CW0 = (SEG_FW > TRUTH_FW) ? SEG_FW : TRUTH_FW;
  localparam int unsigned CW1 = (CW0 > PAIR_FW) ? CW0 : PAIR_FW;
  localparam int unsigned CW  = (CW1 > 13) ? CW1 : 13;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // result status codes
  localparam logic [2:0] ST_COUNTED    = 3'd0;
  localparam logic [2:0] ST_BACKGROUND = 3'd1;
  localparam logic [2:0] ST_DROPPED    = 3'd2;
  localparam logic [2:0] ST_READ_OK    = 3'd3;
  localparam logic [2:0] ST_READ_EMPTY = 3'd4;

  // request kinds
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // table selector codes
  localparam logic [1:0] SEL_SEG   = 2'd0;
  localparam logic [1:0] SEL_TRUTH = 2'd1;
  localparam logic [1:0] SEL_PAIR  = 2'd2;

  typedef struct packed {
    logic [2*KEY_W-1:0]    cand_key;
    logic [2*KEY_W-1:0]    ram_key;
    logic [COUNT_BITS-1:0] count;
  } match_req_t;

  typedef struct packed {
    logic                  hit;
    logic [COUNT_BITS-1:0] inc;
  } match_rsp_t;

endpackage

[sv/lcc_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/lcc_match.sv]
// Shared key compare and saturating count increment.
// Depends on lcc_pkg.
`timescale 1ns / 1ps
module lcc_match (
  input  lcc_pkg::match_req_t req_i,
  output lcc_pkg::match_rsp_t rsp_o
);

  assign rsp_o.hit = (req_i.cand_key == req_i.ram_key);
  assign rsp_o.inc = (req_i.count == lcc_pkg::COUNT_MAX) ? lcc_pkg::COUNT_MAX
                   : req_i.count + lcc_pkg::COUNT_BITS'(1);

endmodule

[sv/label_contingency_counter.sv]
// Top level of the label contingency counter: sequencer, three table RAMs.
// Depends on lcc_pkg, lcc_ram, lcc_match.
`timescale 1ns / 1ps
// Joint label histogram. Each count request carries a segment and a truth
// label; truth label zero is background and changes nothing. Otherwise the
// pair, segment and truth tables are each searched linearly, in order of
// first appearance, through one shared compare/increment unit: a hit
// bumps the saturating count, a miss appends the key if the table has room
// or drops it and sets the sticky overflow flag. Each stored entry that is
// scanned takes a registered RAM read, then a compare. The block takes one
// request at a time (tready only while idle) and holds the result in an
// output register; a new request may be taken while that result waits.
// RAM contents are not cleared, only fill counts reset.
module label_contingency_counter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [63:0] seg_label, [127:64] truth_label, [129:128] table_select,
  // [141:130] entry_index, [143:142] zero
  input  logic [143:0] s_axis_tdata,
  // [0] command
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [63:0] key_first, [127:64] key_second, [167:128] entry_count,
  // [178:168] seg_entries_used, [189:179] truth_entries_used,
  // [202:190] pair_entries_used, [203] overflow_seen, [207:204] zero
  output logic [207:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]   m_axis_tuser
);

  localparam int unsigned KW = lcc_pkg::KEY_W;
  localparam int unsigned NB = lcc_pkg::COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_RD, S_CMP, S_NEW, S_RQ, S_RDAT, S_FIN
  } state_e;

  typedef enum logic [1:0] {TB_PAIR, TB_SEG, TB_TRUTH} tab_e;

  state_e               state_q;
  tab_e                 tab_q;
  logic [lcc_pkg::IW-1:0] idx_q;
  logic [KW-1:0]        seg_q, truth_q;
  logic [11:0]          eidx_q;
  logic                 rdok_q;
  logic [lcc_pkg::SEG_FW-1:0]   seg_fill_q;
  logic [lcc_pkg::TRUTH_FW-1:0] truth_fill_q;
  logic [lcc_pkg::PAIR_FW-1:0]  pair_fill_q;
  logic                 ovf_q;
  logic [2:0]           res_st_q;
  logic [KW-1:0]        res_k1_q, res_k2_q;
  logic [NB-1:0]        res_cnt_q;
  logic                 m_valid_q;
  logic [207:0]         m_data_q;
  logic [2:0]           m_user_q;

  // input fields
  logic [KW-1:0] in_seg, in_truth;
  logic [1:0]    in_sel;
  logic [11:0]   in_idx;
  assign in_seg   = s_axis_tdata[63:0];
  assign in_truth = s_axis_tdata[127:64];
  assign in_sel   = s_axis_tdata[129:128];
  assign in_idx   = s_axis_tdata[141:130];

  logic in_acc;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // RAM ports
  logic                  seg_we, truth_we, pair_we;
  logic [lcc_pkg::IW-1:0] raddr, waddr;
  logic [KW+NB-1:0]      seg_rd, truth_rd;
  logic [2*KW+NB-1:0]    pair_rd;
  logic [2*KW-1:0]       wkey;
  logic [NB-1:0]         wcnt;

  lcc_ram #(.WIDTH(KW + NB), .DEPTH(lcc_pkg::SEG_ENTRIES)) u_seg_ram (
    .clk_i,
    .we_i    (seg_we),
    .waddr_i (lcc_pkg::SEG_AW'(waddr)),
    .wdata_i ({wcnt, wkey[KW-1:0]}),
    .raddr_i (lcc_pkg::SEG_AW'(raddr)),
    .rdata_o (seg_rd)
  );

  lcc_ram #(.WIDTH(KW + NB), .DEPTH(lcc_pkg::TRUTH_ENTRIES)) u_truth_ram (
    .clk_i,
    .we_i    (truth_we),
    .waddr_i (lcc_pkg::TRUTH_AW'(waddr)),
    .wdata_i ({wcnt, wkey[KW-1:0]}),
    .raddr_i (lcc_pkg::TRUTH_AW'(raddr)),
    .rdata_o (truth_rd)
  );

  // pair word: count, truth key, seg key
  lcc_ram #(.WIDTH(2 * KW + NB), .DEPTH(lcc_pkg::PAIR_ENTRIES)) u_pair_ram (
    .clk_i,
    .we_i    (pair_we),
    .waddr_i (lcc_pkg::PAIR_AW'(waddr)),
    .wdata_i ({wcnt, wkey}),
    .raddr_i (lcc_pkg::PAIR_AW'(raddr)),
    .rdata_o (pair_rd)
  );

  // per-table view of the active table
  logic [lcc_pkg::CW-1:0] fill_cur, cap_cur;
  lcc_pkg::match_req_t    mreq;
  lcc_pkg::match_rsp_t    mrsp;

  always_comb begin
    case (tab_q)
      TB_SEG: begin
        fill_cur      = lcc_pkg::CW'(seg_fill_q);
        cap_cur       = lcc_pkg::CW'(lcc_pkg::SEG_ENTRIES);
        mreq.cand_key = {{KW{1'b0}}, seg_q};
        mreq.ram_key  = {{KW{1'b0}}, seg_rd[KW-1:0]};
        mreq.count    = seg_rd[KW+NB-1:KW];
      end
      TB_TRUTH: begin
        fill_cur      = lcc_pkg::CW'(truth_fill_q);
        cap_cur       = lcc_pkg::CW'(lcc_pkg::TRUTH_ENTRIES);
        mreq.cand_key = {{KW{1'b0}}, truth_q};
        mreq.ram_key  = {{KW{1'b0}}, truth_rd[KW-1:0]};
        mreq.count    = truth_rd[KW+NB-1:KW];
      end
      default: begin
        fill_cur      = lcc_pkg::CW'(pair_fill_q);
        cap_cur       = lcc_pkg::CW'(lcc_pkg::PAIR_ENTRIES);
        mreq.cand_key = {truth_q, seg_q};
        mreq.ram_key  = pair_rd[2*KW-1:0];
        mreq.count    = pair_rd[2*KW+NB-1:2*KW];
      end
    endcase
  end

  lcc_match u_match (
    .req_i (mreq),
    .rsp_o (mrsp)
  );

  logic last_ent, tab_full, out_free;
  assign last_ent = (lcc_pkg::CW'(idx_q) + lcc_pkg::CW'(1)) >= fill_cur;
  assign tab_full = fill_cur >= cap_cur;
  assign out_free = !m_valid_q || m_axis_tready;

  // writes: hit rewrites count in place, a new key appends at the fill
  logic do_wr;
  always_comb begin
    do_wr = 1'b0;
    waddr = idx_q;
    wkey  = mreq.cand_key;
    wcnt  = mrsp.inc;
    if (state_q == S_CMP && mrsp.hit) begin
      do_wr = 1'b1;
    end else if (state_q == S_NEW && !tab_full) begin
      do_wr = 1'b1;
      waddr = lcc_pkg::IW'(fill_cur);
      wcnt  = NB'(1);
    end
  end
  assign seg_we   = do_wr && (tab_q == TB_SEG);
  assign truth_we = do_wr && (tab_q == TB_TRUTH);
  assign pair_we  = do_wr && (tab_q == TB_PAIR);
  assign raddr    = (state_q == S_RQ) ? lcc_pkg::IW'(eidx_q) : idx_q;

  // read-request bounds check
  logic rd_ok;
  assign rd_ok = (lcc_pkg::CW'(eidx_q) < fill_cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tab_q        <= TB_PAIR;
      idx_q        <= '0;
      rdok_q       <= 1'b0;
      seg_fill_q   <= '0;
      truth_fill_q <= '0;
      pair_fill_q  <= '0;
      ovf_q        <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      // a result loaded in S_FIN replaces the one leaving
      if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            seg_q     <= in_seg;
            truth_q   <= in_truth;
            eidx_q    <= in_idx;
            res_k1_q  <= '0;
            res_k2_q  <= '0;
            res_cnt_q <= '0;
            if (s_axis_tuser[0] == lcc_pkg::CMD_READ) begin
              rdok_q   <= (in_sel == lcc_pkg::SEL_SEG) ||
                          (in_sel == lcc_pkg::SEL_TRUTH) ||
                          (in_sel == lcc_pkg::SEL_PAIR);
              res_st_q <= lcc_pkg::ST_READ_EMPTY;
              state_q  <= S_RQ;
              case (in_sel)
                lcc_pkg::SEL_SEG:   tab_q <= TB_SEG;
                lcc_pkg::SEL_TRUTH: tab_q <= TB_TRUTH;
                lcc_pkg::SEL_PAIR:  tab_q <= TB_PAIR;
                default: begin
                  tab_q <= TB_PAIR; // unused selector reads empty
                end
              endcase
            end else if (in_truth == '0) begin
              res_st_q <= lcc_pkg::ST_BACKGROUND;
              state_q  <= S_FIN;
            end else begin
              res_st_q <= lcc_pkg::ST_COUNTED;
              tab_q    <= TB_PAIR;
              state_q  <= S_START;
            end
          end
        end
        S_START: begin
          idx_q   <= '0;
          state_q <= (fill_cur == '0) ? S_NEW : S_RD;
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (mrsp.hit) begin
            if (tab_q == TB_TRUTH) begin
              state_q <= S_FIN;
            end else begin
              tab_q   <= (tab_q == TB_PAIR) ? TB_SEG : TB_TRUTH;
              state_q <= S_START;
            end
          end else if (last_ent) begin
            state_q <= S_NEW;
          end else begin
            idx_q   <= idx_q + lcc_pkg::IW'(1);
            state_q <= S_RD;
          end
        end
        S_NEW: begin
          if (tab_full) begin
            res_st_q <= lcc_pkg::ST_DROPPED;
            ovf_q    <= 1'b1;
          end else begin
            case (tab_q)
              TB_SEG:   seg_fill_q   <= seg_fill_q + lcc_pkg::SEG_FW'(1);
              TB_TRUTH: truth_fill_q <= truth_fill_q + lcc_pkg::TRUTH_FW'(1);
              default:  pair_fill_q  <= pair_fill_q + lcc_pkg::PAIR_FW'(1);
            endcase
          end
          if (tab_q == TB_TRUTH) begin
            state_q <= S_FIN;
          end else begin
            tab_q   <= (tab_q == TB_PAIR) ? TB_SEG : TB_TRUTH;
            state_q <= S_START;
          end
        end
        S_RQ: begin
          rdok_q  <= rdok_q && rd_ok;
          state_q <= S_RDAT;
        end
        S_RDAT: begin
          if (rdok_q) begin
            res_st_q  <= lcc_pkg::ST_READ_OK;
            res_cnt_q <= mreq.count;
            if (tab_q == TB_PAIR) begin
              res_k1_q <= mreq.ram_key[2*KW-1:KW];
              res_k2_q <= mreq.ram_key[KW-1:0];
            end else begin
              res_k1_q <= mreq.ram_key[KW-1:0];
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_st_q;
            m_data_q  <= {4'b0, ovf_q, 13'(pair_fill_q), 11'(truth_fill_q),
                          11'(seg_fill_q), 40'(res_cnt_q), res_k2_q, res_k1_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTHESIS
  a_seg_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcc_pkg::CW'(seg_fill_q) <= lcc_pkg::CW'(lcc_pkg::SEG_ENTRIES))
    else $error("segment fill above capacity");
  a_pair_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lcc_pkg::CW'(pair_fill_q) <= lcc_pkg::CW'(lcc_pkg::PAIR_ENTRIES))
    else $error("pair fill above capacity");
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(ovf_q))
    else $error("overflow flag cleared");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("ready right after accepting a request");
`endif

endmodule

[dv/label_contingency_counter_tb.sv]
// Self-checking testbench for label_contingency_counter: a table of directed
// requests, then random count and read traffic, checked against a local model.
// Depends on lcc_pkg and the RTL of the block.
`timescale 1ns / 1ps
module label_contingency_counter_tb;

  typedef struct {
    logic        cmd;
    logic [63:0] seg;
    logic [63:0] truth;
    logic [1:0]  sel;
    logic [11:0] idx;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] key_a;
    logic [63:0] key_b;
    logic [39:0] cnt;
    logic [10:0] seg_used;
    logic [10:0] truth_used;
    logic [12:0] pair_used;
    logic        ovf;
  } rsp_t;

  // directed row: known == 1 means the typed-in result is compared too
  typedef struct {
    req_t r;
    bit   known;
    rsp_t e;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  label_contingency_counter uut (.*);

  always #6 clk_i = ~clk_i;

  // histogram model state
  logic [63:0] seg_keys [lcc_pkg::SEG_ENTRIES];
  logic [39:0] seg_cnts [lcc_pkg::SEG_ENTRIES];
  logic [63:0] tru_keys [lcc_pkg::TRUTH_ENTRIES];
  logic [39:0] tru_cnts [lcc_pkg::TRUTH_ENTRIES];
  logic [63:0] pr_tkeys [lcc_pkg::PAIR_ENTRIES];
  logic [63:0] pr_skeys [lcc_pkg::PAIR_ENTRIES];
  logic [39:0] pr_cnts  [lcc_pkg::PAIR_ENTRIES];
  int unsigned seg_fill, tru_fill, pr_fill;
  bit          ovf_flag;

  rsp_t        pending_rsp [$];
  int          errors = 0;
  int unsigned src_idle = 23, dst_idle = 71;
  bit          hold_off = 1'b0;
  longint      cycle = 0;

  function automatic logic [39:0] sat_inc(logic [39:0] c);
    return (c == lcc_pkg::COUNT_MAX) ? c : c + 40'd1;
  endfunction

  // count one key into a single-key table; 0 if dropped
  function automatic bit bump_single(bit is_seg, logic [63:0] key);
    int unsigned fill;
    fill = is_seg ? seg_fill : tru_fill;
    for (int unsigned i = 0; i < fill; i++) begin
      if (is_seg && seg_keys[i] == key) begin
        seg_cnts[i] = sat_inc(seg_cnts[i]);
        return 1;
      end
      if (!is_seg && tru_keys[i] == key) begin
        tru_cnts[i] = sat_inc(tru_cnts[i]);
        return 1;
      end
    end
    if (fill >= (is_seg ? lcc_pkg::SEG_ENTRIES : lcc_pkg::TRUTH_ENTRIES)) return 0;
    if (is_seg) begin
      seg_keys[fill] = key; seg_cnts[fill] = 40'd1; seg_fill++;
    end else begin
      tru_keys[fill] = key; tru_cnts[fill] = 40'd1; tru_fill++;
    end
    return 1;
  endfunction

  function automatic bit bump_pair(logic [63:0] t, logic [63:0] s);
    for (int unsigned i = 0; i < pr_fill; i++)
      if (pr_tkeys[i] == t && pr_skeys[i] == s) begin
        pr_cnts[i] = sat_inc(pr_cnts[i]);
        return 1;
      end
    if (pr_fill >= lcc_pkg::PAIR_ENTRIES) return 0;
    pr_tkeys[pr_fill] = t; pr_skeys[pr_fill] = s; pr_cnts[pr_fill] = 40'd1;
    pr_fill++;
    return 1;
  endfunction

  function automatic rsp_t histogram_step(req_t r);
    rsp_t o;
    bit   ok_p, ok_s, ok_t;
    o = '{default: '0};
    if (r.cmd == lcc_pkg::CMD_COUNT) begin
      if (r.truth == 0) o.status = lcc_pkg::ST_BACKGROUND;
      else begin
        ok_p = bump_pair(r.truth, r.seg);
        ok_s = bump_single(1, r.seg);
        ok_t = bump_single(0, r.truth);
        if (ok_p && ok_s && ok_t) o.status = lcc_pkg::ST_COUNTED;
        else begin
          o.status = lcc_pkg::ST_DROPPED;
          ovf_flag = 1;
        end
      end
    end else begin
      o.status = lcc_pkg::ST_READ_EMPTY;
      if (r.sel == lcc_pkg::SEL_SEG && r.idx < seg_fill) begin
        o.key_a = seg_keys[r.idx]; o.cnt = seg_cnts[r.idx];
        o.status = lcc_pkg::ST_READ_OK;
      end else if (r.sel == lcc_pkg::SEL_TRUTH && r.idx < tru_fill) begin
        o.key_a = tru_keys[r.idx]; o.cnt = tru_cnts[r.idx];
        o.status = lcc_pkg::ST_READ_OK;
      end else if (r.sel == lcc_pkg::SEL_PAIR && r.idx < pr_fill) begin
        o.key_a = pr_tkeys[r.idx]; o.key_b = pr_skeys[r.idx];
        o.cnt = pr_cnts[r.idx]; o.status = lcc_pkg::ST_READ_OK;
      end
    end
    o.seg_used   = seg_fill[10:0];
    o.truth_used = tru_fill[10:0];
    o.pair_used  = pr_fill[12:0];
    o.ovf        = ovf_flag;
    return o;
  endfunction

  // drive one request and hold it until the block takes it
  task automatic send_request(req_t r, bit known, rsp_t e);
    rsp_t p;
    while (($urandom % 100) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.cmd;
    s_axis_tdata  <= {2'b00, r.idx, r.sel, r.truth, r.seg};
    do @(posedge clk_i); while (!s_axis_tready);
    p = histogram_step(r);
    if (known && p !== e) begin
      errors++;
      if (errors <= 10)
        $display("directed row mismatch: table %p model %p", e, p);
    end
    pending_rsp.push_back(p);
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && (($urandom % 100) >= dst_idle);
  end

  always @(posedge clk_i) begin
    rsp_t a, e;
    cycle <= cycle + 1;
    if (cycle > 40000000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.status = m_axis_tuser;
      {a.ovf, a.pair_used, a.truth_used, a.seg_used, a.cnt, a.key_b, a.key_a}
        = m_axis_tdata[203:0];
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", a);
      end else begin
        e = pending_rsp.pop_front();
        if (a !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", e, a);
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t make_read(logic [1:0] sel, logic [11:0] idx);
    req_t r;
    r = '{cmd: lcc_pkg::CMD_READ, seg: rand64(), truth: rand64(), sel: sel, idx: idx};
    return r;
  endfunction

  function automatic req_t make_count(logic [63:0] s, logic [63:0] t);
    req_t r;
    r = '{cmd: lcc_pkg::CMD_COUNT, seg: s, truth: t, sel: 2'($urandom),
          idx: 12'($urandom)};
    return r;
  endfunction

  // random request; labels drawn from small pools so keys repeat
  function automatic req_t rand_request(int unsigned pool);
    logic [63:0] s, t;
    int unsigned k;
    k = $urandom % 100;
    if (k < 25)
      return make_read(2'($urandom), (k < 20) ? 12'($urandom % (pool + 4)) : 12'($urandom));
    s = ($urandom % 8 == 0) ? rand64() : 64'($urandom % pool) ^ 64'hA5A5_0000_0000_0000;
    t = ($urandom % 10 == 0) ? 64'd0 :
        ($urandom % 8 == 0) ? rand64() : 64'($urandom % pool + 1);
    return make_count(s, t);
  endfunction

  localparam logic [63:0] ONES = '1;

  row_t rows [$];
  rsp_t none;

  initial begin
    none = '{default: '0};
    // after reset, extremes, background and the unused selector
    rows.push_back('{make_read(lcc_pkg::SEL_SEG, 12'd0), 1,
                     '{lcc_pkg::ST_READ_EMPTY, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_read(2'd3, 12'hFFF), 1,
                     '{lcc_pkg::ST_READ_EMPTY, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_count(ONES, 64'd0), 1,
                     '{lcc_pkg::ST_BACKGROUND, 0, 0, 0, 0, 0, 0, 0}});
    rows.push_back('{make_count(ONES, ONES), 1,
                     '{lcc_pkg::ST_COUNTED, 0, 0, 0, 1, 1, 1, 0}});
    rows.push_back('{make_count(64'd0, 64'd1), 1,
                     '{lcc_pkg::ST_COUNTED, 0, 0, 0, 2, 2, 2, 0}});
    rows.push_back('{make_count(ONES, ONES), 0, none});
    rows.push_back('{make_read(lcc_pkg::SEL_PAIR, 12'd0), 1,
                     '{lcc_pkg::ST_READ_OK, ONES, ONES, 40'd2, 2, 2, 2, 0}});
    rows.push_back('{make_read(lcc_pkg::SEL_SEG, 12'd1), 1,
                     '{lcc_pkg::ST_READ_OK, 64'd0, 0, 40'd1, 2, 2, 2, 0}});
    rows.push_back('{make_read(lcc_pkg::SEL_TRUTH, 12'd1), 1,
                     '{lcc_pkg::ST_READ_OK, 64'd1, 0, 40'd1, 2, 2, 2, 0}});
    rows.push_back('{make_read(lcc_pkg::SEL_PAIR, 12'd2), 1,
                     '{lcc_pkg::ST_READ_EMPTY, 0, 0, 0, 2, 2, 2, 0}});
    rows.push_back('{make_read(2'd3, 12'd0), 1,
                     '{lcc_pkg::ST_READ_EMPTY, 0, 0, 0, 2, 2, 2, 0}});
    rows.push_back('{make_count(64'd0, ONES), 0, none});
    rows.push_back('{make_count(64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555), 0, none});
    rows.push_back('{make_count(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA), 0, none});
    rows.push_back('{make_read(lcc_pkg::SEL_PAIR, 12'd3), 0, none});
    rows.push_back('{make_read(lcc_pkg::SEL_SEG, 12'hFFF), 0, none});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_request(rows[i].r, rows[i].known, rows[i].e);

    // phase 1: sender busy, receiver slow; long receiver hold-off midway
    for (int n = 0; n < 300; n++) begin
      if (n == 200) begin
        hold_off <= 1'b1;
        fork begin repeat (400) @(posedge clk_i); hold_off <= 1'b0; end join_none
      end
      send_request(rand_request(12), 0, none);
    end
    src_idle = 71; dst_idle = 23;
    for (int n = 0; n < 250; n++) send_request(rand_request(40), 0, none);
    src_idle = 0; dst_idle = 0;
    for (int n = 0; n < 250; n++) send_request(rand_request(60), 0, none);
    // fill the segment table past capacity with distinct labels under few
    // truths so the segment table overflows while scans stay bounded
    for (int n = 0; n < 1000; n++) begin
      if (n % 16 == 0) send_request(rand_request(60), 0, none);
      else send_request(make_count(64'h1_0000 + n, 64'd7), 0, none);
    end
    for (int n = 0; n < 40; n++)
      send_request(make_read(2'($urandom), 12'($urandom % 1100)), 0, none);
    send_request(make_read(lcc_pkg::SEL_SEG, 12'd1023), 0, none);
    s_axis_tvalid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
